// ===== rtl/rivn_pkg.sv =====
package rivn_pkg;

  // Stream positions
  localparam int unsigned BodyLen = 17;
  localparam logic [4:0] POS_LAST = 5'd17;
  localparam logic [4:0] POS_BODY = 5'd17;
  localparam logic [4:0] POS_SAT = 5'd19;
  localparam logic [13:0] MIN_YEAR = 14'd1900;

  // Configuration register indexes
  localparam logic [1:0] REG_YEAR = 2'd0;
  localparam logic [1:0] REG_MONTH = 2'd1;
  localparam logic [1:0] REG_DAY = 2'd2;

  // Result queue depth
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BAD_LENGTH = 3'd1,
    ST_BAD_CHAR = 3'd2,
    ST_BAD_CHECK = 3'd3,
    ST_BAD_DATE = 3'd4
  } status_t;

  // One finished ID number, as handed from the front to the back
  typedef struct packed {
    logic        len_bad;
    logic        char_bad;
    logic [7:0]  check_char;
    logic [9:0]  wsum;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  year_hi;
    logic [6:0]  year_lo;
    logic        sex_odd;
  } rivn_rec_t;

  // Today's date from the configuration registers
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } rivn_date_t;

  // Weight of each body digit
  function automatic logic [3:0] digit_weight(input logic [4:0] pos);
    logic [3:0] w;
    case (pos)
      5'd0: w = 4'd7;
      5'd1: w = 4'd9;
      5'd2: w = 4'd10;
      5'd3: w = 4'd5;
      5'd4: w = 4'd8;
      5'd5: w = 4'd4;
      5'd6: w = 4'd2;
      5'd7: w = 4'd1;
      5'd8: w = 4'd6;
      5'd9: w = 4'd3;
      5'd10: w = 4'd7;
      5'd11: w = 4'd9;
      5'd12: w = 4'd10;
      5'd13: w = 4'd5;
      5'd14: w = 4'd8;
      5'd15: w = 4'd4;
      5'd16: w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // Expected check character for a residue mod 11
  function automatic logic [7:0] check_symbol(input logic [3:0] res);
    logic [7:0] s;
    case (res)
      4'd0: s = "1";
      4'd1: s = "0";
      4'd2: s = "X";
      4'd3: s = "9";
      4'd4: s = "8";
      4'd5: s = "7";
      4'd6: s = "6";
      4'd7: s = "5";
      4'd8: s = "4";
      4'd9: s = "3";
      4'd10: s = "2";
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/rivn_front.sv =====
module rivn_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,  // [7:0] char_code
  input  logic                s_tlast,  // last_char
  input  logic                q_full,
  output logic                q_push,
  output rivn_pkg::rivn_rec_t q_wdata
);
  import rivn_pkg::*;

  logic [4:0]  position;
  logic        chars_ok;
  logic [9:0]  wsum;
  logic [13:0] year_acc;
  logic [6:0]  year_hi;
  logic [6:0]  year_lo;
  logic [6:0]  month_acc;
  logic [6:0]  day_acc;
  logic        sex_odd;

  logic        xfer;
  logic        digit;
  logic [3:0]  dval;
  logic        take;
  logic        chars_ok_next;
  logic [9:0]  wsum_next;
  logic [13:0] year_next;
  logic [6:0]  year_hi_next;
  logic [6:0]  year_lo_next;
  logic [6:0]  month_next;
  logic [6:0]  day_next;
  logic        sex_next;
  logic [7:0]  wprod;

  assign s_tready = !q_full;
  assign xfer = s_tvalid && s_tready;

  // Classify the byte
  assign digit = (s_tdata >= "0") && (s_tdata <= "9");
  assign dval = digit ? 4'(s_tdata - "0") : 4'd0;
  assign take = (position < POS_BODY) && digit;
  assign wprod = {4'd0, dval} * {4'd0, digit_weight(position)};

  // Updated stream fields including this byte
  always_comb begin
    chars_ok_next = chars_ok;
    wsum_next = wsum;
    year_next = year_acc;
    year_hi_next = year_hi;
    year_lo_next = year_lo;
    month_next = month_acc;
    day_next = day_acc;
    sex_next = sex_odd;
    if ((position < POS_BODY) && !digit) begin
      chars_ok_next = 1'b0;
    end
    if (take) begin
      wsum_next = wsum + {2'd0, wprod};
      case (position)
        5'd6, 5'd7: begin
          year_next = 14'({year_acc, 3'd0} + {year_acc, 1'b0} + {10'd0, dval});
          year_hi_next = 7'({year_hi, 3'd0} + {year_hi, 1'b0} + {3'd0, dval});
        end
        5'd8, 5'd9: begin
          year_next = 14'({year_acc, 3'd0} + {year_acc, 1'b0} + {10'd0, dval});
          year_lo_next = 7'({year_lo, 3'd0} + {year_lo, 1'b0} + {3'd0, dval});
        end
        5'd10, 5'd11: month_next = 7'({month_acc, 3'd0} + {month_acc, 1'b0} + {3'd0, dval});
        5'd12, 5'd13: day_next = 7'({day_acc, 3'd0} + {day_acc, 1'b0} + {3'd0, dval});
        5'd16: sex_next = dval[0];
        default: ;
      endcase
    end
  end

  // Build the record for the final byte
  always_comb begin
    q_push = xfer && s_tlast;
    q_wdata.len_bad = (position != POS_LAST);
    q_wdata.char_bad = !chars_ok_next ||
                       !(digit || (s_tdata == "X") || (s_tdata == "x"));
    q_wdata.check_char = (s_tdata == "x") ? 8'("X") : s_tdata;
    q_wdata.wsum = wsum_next;
    q_wdata.year = year_next;
    q_wdata.month = month_next;
    q_wdata.day = day_next;
    q_wdata.year_hi = year_hi_next;
    q_wdata.year_lo = year_lo_next;
    q_wdata.sex_odd = sex_next;
  end

  // Advance the stream state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst || (xfer && s_tlast)) begin
      position <= 5'd0;
      chars_ok <= 1'b1;
      wsum <= 10'd0;
      year_acc <= 14'd0;
      year_hi <= 7'd0;
      year_lo <= 7'd0;
      month_acc <= 7'd0;
      day_acc <= 7'd0;
      sex_odd <= 1'b0;
    end else if (xfer) begin
      if (position < POS_SAT) begin
        position <= position + 5'd1;
      end
      chars_ok <= chars_ok_next;
      wsum <= wsum_next;
      year_acc <= year_next;
      year_hi <= year_hi_next;
      year_lo <= year_lo_next;
      month_acc <= month_next;
      day_acc <= day_next;
      sex_odd <= sex_next;
    end
  end

endmodule

// ===== rtl/rivn_queue.sv =====
module rivn_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rivn_pkg::rivn_rec_t wdata,
  output logic                full,
  input  logic                pop,
  output rivn_pkg::rivn_rec_t rdata,
  output logic                empty
);
  import rivn_pkg::*;

  rivn_rec_t           mem [QDepth];
  logic [QPtrW-1:0]    wptr;
  logic [QPtrW-1:0]    rptr;
  logic [QPtrW:0]      count;
  logic                do_push;
  logic                do_pop;

  assign full = (count == (QPtrW+1)'(QDepth));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rptr];

  // Store records
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rivn_back.sv =====
module rivn_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rivn_pkg::rivn_date_t today,
  input  logic                 q_empty,
  input  rivn_pkg::rivn_rec_t  q_rdata,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [2:0] status, [3] id_valid, [17:4] birth_year, [24:18] birth_month,
  // [31:25] birth_day, [45:32] age_years, [46] is_male, [47] zero
  output logic [47:0]          m_tdata
);
  import rivn_pkg::*;

  status_t     status;
  logic        valid;
  logic [17:0] qprod;
  logic [6:0]  quot;
  logic [9:0]  rem_wide;
  logic [4:0]  rem_raw;
  logic [3:0]  residue;
  logic        leap;
  logic [4:0]  mdays;
  logic        date_bad;
  logic        dec;
  logic [15:0] age_diff;
  logic [13:0] age;
  logic        hide_birth;
  logic [47:0] result;

  function automatic logic [4:0] month_days(input logic lp, input logic [6:0] m);
    logic [4:0] n;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11: n = 5'd30;
      7'd2: n = lp ? 5'd29 : 5'd28;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  assign q_pop = !q_empty && (!m_tvalid || m_tready);

  // Residue mod 11 by reciprocal, one correction step
  assign qprod = {8'd0, q_rdata.wsum} * 18'd186;
  assign quot = qprod[17:11];
  assign rem_wide = q_rdata.wsum - ({3'd0, quot} + {2'd0, quot, 1'b0} + {quot, 3'd0});
  assign rem_raw = rem_wide[4:0];
  assign residue = (rem_raw >= 5'd11) ? 4'(rem_raw - 5'd11) : rem_raw[3:0];

  // Date range and leap year from the two year halves
  assign leap = ((q_rdata.year_lo[1:0] == 2'd0) && (q_rdata.year_lo != 7'd0)) ||
                ((q_rdata.year_lo == 7'd0) && (q_rdata.year_hi[1:0] == 2'd0));
  assign mdays = month_days(leap, q_rdata.month);
  assign date_bad = (q_rdata.year < MIN_YEAR) || (q_rdata.year > today.year) ||
                    (q_rdata.month < 7'd1) || (q_rdata.month > 7'd12) ||
                    (q_rdata.day < 7'd1) || (q_rdata.day > {2'd0, mdays});

  // Pick status by priority
  always_comb begin
    if (q_rdata.len_bad) begin
      status = ST_BAD_LENGTH;
    end else if (q_rdata.char_bad) begin
      status = ST_BAD_CHAR;
    end else if (check_symbol(residue) != q_rdata.check_char) begin
      status = ST_BAD_CHECK;
    end else if (date_bad) begin
      status = ST_BAD_DATE;
    end else begin
      status = ST_OK;
    end
  end
  assign valid = (status == ST_OK);

  // Completed years, saturated
  assign dec = ({3'd0, today.month} < q_rdata.month) ||
               (({3'd0, today.month} == q_rdata.month) && ({2'd0, today.day} < q_rdata.day));
  assign age_diff = {2'd0, today.year} - {2'd0, q_rdata.year} - {15'd0, dec};
  always_comb begin
    if (!valid) begin
      age = 14'd0;
    end else if (!age_diff[15] && (age_diff > 16'd8191)) begin
      age = 14'd8191;
    end else begin
      age = age_diff[13:0];
    end
  end

  assign hide_birth = (status == ST_BAD_LENGTH) || (status == ST_BAD_CHAR);
  assign result = {1'b0,
                   valid && q_rdata.sex_odd,
                   age,
                   hide_birth ? 7'd0 : q_rdata.day,
                   hide_birth ? 7'd0 : q_rdata.month,
                   hide_birth ? 14'd0 : q_rdata.year,
                   valid,
                   status};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (q_pop) begin
      m_tdata <= result;
    end
  end

`ifndef SYNTH
  a_valid_matches_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] == ST_OK)))
    else $error("id_valid disagrees with status");
  a_fields_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[3]) |-> ((m_tdata[45:32] == 14'd0) && !m_tdata[46]))
    else $error("age or sex set on a rejected ID");
  a_birth_hidden: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tdata[2:0] == ST_BAD_LENGTH) || (m_tdata[2:0] == ST_BAD_CHAR)))
      |-> (m_tdata[31:4] == 28'd0))
    else $error("birth fields shown on bad length or character");
  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && !m_tvalid) |=> m_tvalid)
    else $error("queued record not moved to the output");
`endif

endmodule

// ===== rtl/resident_id_number_validator.sv =====
// A result passes through the queue and the output register before it is valid on m_tdata.
// Throughput: one byte per cycle while the queue is not full; one result per ID
// number. A four-entry queue lets the front keep taking bytes while results wait
// at the output register.
// Reset: synchronous, active high; clears stream state, queue and output valid,
// and sets the date registers to 2025-01-01.
module resident_id_number_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] status, [3] id_valid, [17:4] birth_year, [24:18] birth_month,
  // [31:25] birth_day, [45:32] age_years, [46] is_male, [47] zero
  output logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rivn_pkg::*;

  rivn_date_t today;
  rivn_rec_t  q_wdata;
  rivn_rec_t  q_rdata;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Date registers
  always_ff @(posedge clk) begin
    if (rst) begin
      today.year <= 14'd2025;
      today.month <= 4'd1;
      today.day <= 5'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_YEAR: today.year <= pwdata[13:0];
        REG_MONTH: today.month <= pwdata[3:0];
        REG_DAY: today.day <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_YEAR: prdata = {18'd0, today.year};
      REG_MONTH: prdata = {28'd0, today.month};
      REG_DAY: prdata = {27'd0, today.day};
      default: prdata = 32'd0;
    endcase
  end

  rivn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  rivn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rivn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .today    (today),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rivn_pkg::*;

  // Scoreboard: tracks one ID number in flight and queues the verdict (status and fields) it must produce
  class id_scoreboard;

    typedef struct {
      status_t    status;
      bit         ok;
      bit [13:0]  year;
      bit [6:0]   month;
      bit [6:0]   day;
      bit [13:0]  age;
      bit         male;
    } id_verdict_t;

    id_verdict_t verdict_q[$];

    int    weights[17] = '{7, 9, 10, 5, 8, 4, 2, 1, 6, 3, 7, 9, 10, 5, 8, 4, 2};
    string check_chars = "10X98765432";

    // Today's date as programmed
    bit [13:0] today_year;
    bit [3:0]  today_month;
    bit [4:0]  today_day;

    // Per-number parse state
    bit [4:0]  pos;
    bit        body_ok;
    bit [9:0]  wsum;
    bit [13:0] yr;
    bit [6:0]  mo;
    bit [6:0]  dy;
    bit        odd;

    int errors;
    int chars_seen;
    int numbers_checked;
    int status_count[5];

    function new();
      today_year = 14'd2025;
      today_month = 4'd1;
      today_day = 5'd1;
      clear_number();
    endfunction

    function void clear_number();
      pos = '0;
      body_ok = 1'b1;
      wsum = '0;
      yr = '0;
      mo = '0;
      dy = '0;
      odd = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned value);
      case (idx)
        REG_YEAR: today_year = value[13:0];
        REG_MONTH: today_month = value[3:0];
        REG_DAY: today_day = value[4:0];
        default: ;
      endcase
    endfunction

    function int unsigned reg_value(logic [1:0] idx);
      case (idx)
        REG_YEAR: return today_year;
        REG_MONTH: return today_month;
        REG_DAY: return today_day;
        default: return 0;
      endcase
    endfunction

    function int days_in_month(int y, int m);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11: return 30;
        2: return leap ? 29 : 28;
        default: return 0;
      endcase
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // Advance the parse on one accepted character; queue a verdict on the final one
    function void note_char(bit [7:0] c, bit last);
      bit          is_digit;
      int          d;
      int          a;
      bit [7:0]    act;
      id_verdict_t v;
      is_digit = (c >= "0") && (c <= "9");
      d = is_digit ? c - "0" : 0;
      chars_seen++;

      if (pos < 17) begin
        if (!is_digit) begin
          body_ok = 1'b0;
        end else begin
          wsum = 10'(wsum + d * weights[pos]);
          if (pos >= 6 && pos <= 9) yr = 14'(yr * 10 + d);
          else if (pos == 10 || pos == 11) mo = 7'(mo * 10 + d);
          else if (pos == 12 || pos == 13) dy = 7'(dy * 10 + d);
          else if (pos == 16) odd = d[0];
        end
      end

      if (!last) begin
        if (pos < 19) pos++;
        return;
      end

      // Status in priority order: length, characters, check, date
      act = (c == "x") ? "X" : c;
      if (pos != 17) v.status = ST_BAD_LENGTH;
      else if (!body_ok || !(is_digit || act == "X")) v.status = ST_BAD_CHAR;
      else if (check_chars[wsum % 11] != act) v.status = ST_BAD_CHECK;
      else if (yr < 1900 || yr > today_year || mo < 1 || mo > 12 || dy < 1 ||
               dy > days_in_month(yr, mo)) v.status = ST_BAD_DATE;
      else v.status = ST_OK;

      v.ok = (v.status == ST_OK);
      if (v.status == ST_BAD_LENGTH || v.status == ST_BAD_CHAR) begin
        v.year = '0;
        v.month = '0;
        v.day = '0;
      end else begin
        v.year = yr;
        v.month = mo;
        v.day = dy;
      end

      a = 0;
      if (v.ok) begin
        a = int'(today_year) - int'(yr);
        if (today_month < mo || (today_month == mo && today_day < dy)) a--;
        if (a > 8191) a = 8191;
      end
      v.age = a[13:0];
      v.male = v.ok ? odd : 1'b0;

      status_count[v.status]++;
      verdict_q.push_back(v);
      clear_number();
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Compare one accepted result with the oldest verdict
    task check_result(logic [47:0] data);
      id_verdict_t v;
      if (verdict_q.size() == 0) begin
        report_mismatch("result with no ID number pending", data, 0);
        return;
      end
      v = verdict_q.pop_front();
      numbers_checked++;
      if (data[2:0] !== v.status) report_mismatch("status", data[2:0], v.status);
      if (data[3] !== v.ok) report_mismatch("id_valid", data[3], v.ok);
      if (data[17:4] !== v.year) report_mismatch("birth_year", data[17:4], v.year);
      if (data[24:18] !== v.month) report_mismatch("birth_month", data[24:18], v.month);
      if (data[31:25] !== v.day) report_mismatch("birth_day", data[31:25], v.day);
      if (data[45:32] !== v.age) report_mismatch("age_years", data[45:32], v.age);
      if (data[46] !== v.male) report_mismatch("is_male", data[46], v.male);
      if (data[47] !== 1'b0) report_mismatch("pad bit", data[47], 0);
    endtask

  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] char_code
  logic        s_tlast = 1'b0; // last_char
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [2:0] status, [3] id_valid, [17:4] birth_year, [24:18] birth_month,
  // [31:25] birth_day, [45:32] age_years, [46] is_male, [47] zero
  logic [47:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  id_scoreboard sb;
  bit [7:0]     id_buf[$];
  bit           sink_fast = 1'b0;
  int           stall;
  int           ready_wait = 0;

  resident_id_number_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: check each transfer, then hold off for a random stall
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      sb.check_result(m_tdata);
      if ($urandom_range(0, 15) == 0) sink_fast = !sink_fast;
      stall = sink_fast ? 0 : $urandom_range(0, 10);
      m_tready <= (stall == 0);
      ready_wait <= stall;
    end else if (ready_wait > 0) begin
      m_tready <= (ready_wait == 1);
      ready_wait <= ready_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Present one character, after a random gap unless in a burst, and wait for its transfer
  task automatic push_char(bit [7:0] c, bit last, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_char(c, last);
  endtask

  task automatic send_number();
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (id_buf[i]) push_char(id_buf[i], i == id_buf.size() - 1, burst);
  endtask

  // Drop valid and let the block drain before touching registers
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apb_read(logic [1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sb.reg_value(idx)) sb.report_mismatch("register readback", prdata,
                                                         sb.reg_value(idx));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int body_residue();
    int sum;
    sum = 0;
    for (int i = 0; i < 17; i++) sum += (id_buf[i] - "0") * sb.weights[i];
    return sum % 11;
  endfunction

  function automatic void push_digit(int v);
    id_buf.push_back(8'("0" + v));
  endfunction

  // Build a well-formed number with the given date; force a residue when asked
  function automatic void build_id(int y, int m, int d, int want_res);
    id_buf.delete();
    push_digit($urandom_range(1, 9));
    repeat (5) push_digit($urandom_range(0, 9));
    push_digit(y / 1000 % 10);
    push_digit(y / 100 % 10);
    push_digit(y / 10 % 10);
    push_digit(y % 10);
    push_digit(m / 10 % 10);
    push_digit(m % 10);
    push_digit(d / 10 % 10);
    push_digit(d % 10);
    repeat (3) push_digit($urandom_range(0, 9));
    while (want_res >= 0 && body_residue() != want_res)
      for (int i = 14; i < 17; i++) id_buf[i] = 8'("0" + $urandom_range(0, 9));
    id_buf.push_back(sb.check_chars[body_residue()]);
  endfunction

  function automatic void set_length(int n);
    while (id_buf.size() > n) void'(id_buf.pop_back());
    while (id_buf.size() < n) push_digit($urandom_range(0, 9));
  endfunction

  // Swap in a check character that is valid in form but wrong
  function automatic void spoil_check();
    id_buf[17] = (id_buf[17] == "1") ? "2" : "1";
  endfunction

  function automatic void random_date(output int y, output int m, output int d);
    int top;
    int dim;
    top = (sb.today_year > 9999) ? 9999 : sb.today_year;
    case ($urandom_range(0, 9))
      0: y = $urandom_range(0, 9999);
      1: y = (top >= 9999) ? 9999 : top + 1;
      2: y = $urandom_range(1899, 1900);
      3: y = $urandom_range(1900, top);
      default: y = $urandom_range(top, (top > 100) ? top - 100 : 0);
    endcase
    m = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    // Birthdays near today exercise the age rollover
    if ($urandom_range(0, 5) == 0) begin
      y = top;
      m = sb.today_month;
    end
    dim = sb.days_in_month(y, m);
    case ($urandom_range(0, 7))
      0: d = $urandom_range(0, 99);
      1: d = dim + 1;
      2: d = sb.today_day + $urandom_range(0, 2) - 1;
      default: d = $urandom_range(1, (dim == 0) ? 31 : dim);
    endcase
    if (d < 0) d = 0;
    if (d > 99) d = 99;
  endfunction

  task automatic send_dated(int y, int m, int d);
    build_id(y, m, d, -1);
    send_number();
  endtask

  task automatic send_random_number();
    int y, m, d, p, n;
    bit [7:0] c;
    random_date(y, m, d);
    case ($urandom_range(0, 19))
      11: begin
        build_id(y, m, d, 2);
        if ($urandom_range(0, 1)) id_buf[17] = "x";
      end
      12, 13: begin
        build_id(y, m, d, -1);
        spoil_check();
      end
      14, 15: begin
        build_id(y, m, d, -1);
        p = $urandom_range(0, 17);
        do c = 8'($urandom_range(0, 255));
        while ((c >= "0" && c <= "9") || (p == 17 && (c == "X" || c == "x")));
        id_buf[p] = c;
      end
      16, 17: begin
        build_id(y, m, d, -1);
        do n = $urandom_range(1, 30); while (n == 18);
        set_length(n);
      end
      18, 19: begin
        id_buf.delete();
        repeat ($urandom_range(1, 25)) id_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: build_id(y, m, d, -1);
    endcase
    send_number();
  endtask

  // Directed cases against the reset date of 2025-01-01
  task automatic run_directed();
    // lone byte of all zeros, then all ones
    id_buf = '{8'h00};
    send_number();
    id_buf = '{8'hFF};
    send_number();
    send_dated(1990, 5, 17);
    // check character X, upper and lower case
    build_id(1985, 12, 31, 2);
    send_number();
    id_buf[17] = "x";
    send_number();
    build_id(1970, 3, 3, -1);
    spoil_check();
    send_number();
    // non-digit in the body, and a bad final character
    build_id(1970, 3, 3, -1);
    id_buf[3] = 8'hFF;
    send_number();
    build_id(1970, 3, 3, -1);
    id_buf[17] = "Y";
    send_number();
    // short number with a bad character reports length first
    build_id(1970, 3, 3, -1);
    id_buf[5] = "A";
    set_length(17);
    send_number();
    build_id(1970, 3, 3, -1);
    set_length(19);
    send_number();
    // long run keeps the position saturated
    build_id(1970, 3, 3, -1);
    set_length(30);
    send_number();
    // wrong check wins over a bad date
    build_id(1899, 6, 1, -1);
    spoil_check();
    send_number();
    // dates around the limits
    send_dated(1899, 6, 1);
    send_dated(2026, 1, 1);
    send_dated(2000, 0, 10);
    send_dated(2000, 13, 10);
    send_dated(2000, 4, 31);
    send_dated(2000, 5, 0);
    send_dated(1900, 2, 29);
    send_dated(2023, 2, 29);
    send_dated(2000, 2, 29);
    send_dated(2024, 2, 29);
    send_dated(1900, 1, 1);
    send_dated(2025, 1, 1);
    // born later this year: one year short of zero
    send_dated(2025, 12, 31);
  endtask

  initial begin
    int cfg_y[8];
    int cfg_m[8];
    int cfg_d[8];
    int phase_start;
    cfg_y = '{2025, 9999, 1900, 16383, 0, 2000, 0, 2025};
    cfg_m = '{1, 12, 1, 15, 0, 2, 0, 6};
    cfg_d = '{1, 31, 1, 31, 0, 29, 0, 15};
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read(REG_YEAR);
    apb_read(REG_MONTH);
    apb_read(REG_DAY);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        run_directed();
      end else begin
        wait_idle();
        if (ph == 6) begin
          cfg_y[ph] = $urandom_range(1950, 2100);
          cfg_m[ph] = $urandom_range(1, 12);
          cfg_d[ph] = $urandom_range(1, 31);
        end
        apb_write(REG_YEAR, cfg_y[ph]);
        apb_write(REG_MONTH, cfg_m[ph]);
        apb_write(REG_DAY, cfg_d[ph]);
        apb_read(REG_YEAR);
        apb_read(REG_MONTH);
        apb_read(REG_DAY);
      end
      phase_start = sb.chars_seen;
      while (sb.chars_seen - phase_start < 130) send_random_number();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d characters, checked %0d ID numbers over 8 date settings",
             sb.chars_seen, sb.numbers_checked);
    $display("Status mix: ok %0d, length %0d, character %0d, check %0d, date %0d",
             sb.status_count[ST_OK], sb.status_count[ST_BAD_LENGTH],
             sb.status_count[ST_BAD_CHAR], sb.status_count[ST_BAD_CHECK],
             sb.status_count[ST_BAD_DATE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
